/* sv/pbc_pkg.sv */
// Shared types, constants and codes of the point box centroid block.
package pbc_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int COUNT_WIDTH   = 21;
  localparam int MAX_POINTS    = 1048576;
  localparam int SUM_WIDTH     = 36;
  localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);

  localparam int APB_DATA_WIDTH = 32;
  localparam int NUM_REGS       = 6;
  localparam int REG_IDX_WIDTH  = $clog2(NUM_REGS);
  localparam int APB_ADDR_WIDTH = REG_IDX_WIDTH + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  localparam coord_t Y_LOW_RESET     = COORD_WIDTH'(410);
  localparam coord_t Y_HIGH_RESET    = COORD_WIDTH'(2048);
  localparam coord_t X_LOW_RESET     = COORD_WIDTH'(-819);
  localparam coord_t X_HIGH_RESET    = COORD_WIDTH'(819);
  localparam coord_t DEPTH_RESET     = COORD_WIDTH'(4096);
  localparam count_t MIN_COUNT_RESET = COUNT_WIDTH'(4000);
  localparam coord_t COORD_MAX       = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_Y_LOW     = 3'd0,
    REG_Y_HIGH    = 3'd1,
    REG_X_LOW     = 3'd2,
    REG_X_HIGH    = 3'd3,
    REG_DEPTH     = 3'd4,
    REG_MIN_COUNT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    coord_t y_low_bound;
    coord_t y_high_bound;
    coord_t x_low_bound;
    coord_t x_high_bound;
    coord_t depth_limit;
    count_t min_point_count;
  } pbc_cfg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PREP,
    ST_DIV,
    ST_LOAD
  } pbc_state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic load;
  } pbc_cmd_t;

  typedef struct packed {
    logic centroid_found;
    logic div_last;
    logic out_busy;
  } pbc_stat_t;

endpackage

/* sv/pbc_if.sv */
// Valid/ready channel interfaces for points in and centroid results out.
interface pbc_point_if;
  logic               valid;
  logic               ready;
  pbc_pkg::coord_t    point_x;
  pbc_pkg::coord_t    point_y;
  pbc_pkg::coord_t    point_z;
  logic               point_valid;
  logic               frame_last;

  modport source (output valid, point_x, point_y, point_z, point_valid, frame_last,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, frame_last,
                output ready);
endinterface

interface pbc_result_if;
  logic               valid;
  logic               ready;
  logic               centroid_found;
  pbc_pkg::coord_t    centroid_x;
  pbc_pkg::coord_t    centroid_y;
  pbc_pkg::coord_t    nearest_z;

  modport source (output valid, centroid_found, centroid_x, centroid_y, nearest_z,
                  input ready);
  modport sink (input valid, centroid_found, centroid_x, centroid_y, nearest_z,
                output ready);
endinterface

/* sv/pbc_regs.sv */
// APB configuration register file.
module pbc_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pbc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [pbc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [pbc_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready,
  output pbc_pkg::pbc_cfg_t                    cfg
);

  localparam int EXT_WIDTH = pbc_pkg::APB_DATA_WIDTH - pbc_pkg::COORD_WIDTH;
  localparam int CNT_EXT   = pbc_pkg::APB_DATA_WIDTH - pbc_pkg::COUNT_WIDTH;

  pbc_pkg::reg_idx_t idx;

  assign idx    = pbc_pkg::reg_idx_t'(paddr[pbc_pkg::APB_ADDR_WIDTH-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.y_low_bound     <= pbc_pkg::Y_LOW_RESET;
      cfg.y_high_bound    <= pbc_pkg::Y_HIGH_RESET;
      cfg.x_low_bound     <= pbc_pkg::X_LOW_RESET;
      cfg.x_high_bound    <= pbc_pkg::X_HIGH_RESET;
      cfg.depth_limit     <= pbc_pkg::DEPTH_RESET;
      cfg.min_point_count <= pbc_pkg::MIN_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        pbc_pkg::REG_Y_LOW:     cfg.y_low_bound     <= pwdata[pbc_pkg::COORD_WIDTH-1:0];
        pbc_pkg::REG_Y_HIGH:    cfg.y_high_bound    <= pwdata[pbc_pkg::COORD_WIDTH-1:0];
        pbc_pkg::REG_X_LOW:     cfg.x_low_bound     <= pwdata[pbc_pkg::COORD_WIDTH-1:0];
        pbc_pkg::REG_X_HIGH:    cfg.x_high_bound    <= pwdata[pbc_pkg::COORD_WIDTH-1:0];
        pbc_pkg::REG_DEPTH:     cfg.depth_limit     <= pwdata[pbc_pkg::COORD_WIDTH-1:0];
        pbc_pkg::REG_MIN_COUNT: cfg.min_point_count <= pwdata[pbc_pkg::COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pbc_pkg::REG_Y_LOW:
        prdata = {{EXT_WIDTH{cfg.y_low_bound[pbc_pkg::COORD_WIDTH-1]}}, cfg.y_low_bound};
      pbc_pkg::REG_Y_HIGH:
        prdata = {{EXT_WIDTH{cfg.y_high_bound[pbc_pkg::COORD_WIDTH-1]}}, cfg.y_high_bound};
      pbc_pkg::REG_X_LOW:
        prdata = {{EXT_WIDTH{cfg.x_low_bound[pbc_pkg::COORD_WIDTH-1]}}, cfg.x_low_bound};
      pbc_pkg::REG_X_HIGH:
        prdata = {{EXT_WIDTH{cfg.x_high_bound[pbc_pkg::COORD_WIDTH-1]}}, cfg.x_high_bound};
      pbc_pkg::REG_DEPTH:
        prdata = {{EXT_WIDTH{cfg.depth_limit[pbc_pkg::COORD_WIDTH-1]}}, cfg.depth_limit};
      pbc_pkg::REG_MIN_COUNT:
        prdata = {{CNT_EXT{1'b0}}, cfg.min_point_count};
      default:
        prdata = '0;
    endcase
  end

endmodule

/* sv/pbc_ctrl.sv */
// Frame controller: point intake, divide sequencing and result hand-off.
module pbc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  pbc_pkg::pbc_stat_t  stat,
  output pbc_pkg::pbc_cmd_t   cmd
);

  pbc_pkg::pbc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbc_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pbc_pkg::ST_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_next = pbc_pkg::ST_PREP;
        end
      end
      pbc_pkg::ST_PREP: begin
        cmd.start  = 1'b1;
        // no centroid: skip the divide, the result is all zero
        state_next = stat.centroid_found ? pbc_pkg::ST_DIV : pbc_pkg::ST_LOAD;
      end
      pbc_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_next = pbc_pkg::ST_LOAD;
        end
      end
      pbc_pkg::ST_LOAD: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = pbc_pkg::ST_RUN;
        end
      end
      default: state_next = pbc_pkg::ST_RUN;
    endcase
  end

endmodule

/* sv/pbc_dp.sv */
// Datapath: box test, accumulators, restoring divider and output register.
module pbc_dp (
  input  logic                clk,
  input  logic                rst,
  input  pbc_pkg::pbc_cfg_t   cfg,
  input  pbc_pkg::pbc_cmd_t   cmd,
  output pbc_pkg::pbc_stat_t  stat,
  input  pbc_pkg::coord_t     point_x,
  input  pbc_pkg::coord_t     point_y,
  input  pbc_pkg::coord_t     point_z,
  input  logic                point_valid,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                centroid_found,
  output pbc_pkg::coord_t     centroid_x,
  output pbc_pkg::coord_t     centroid_y,
  output pbc_pkg::coord_t     nearest_z
);

  localparam int CW = pbc_pkg::COORD_WIDTH;
  localparam int NW = pbc_pkg::COUNT_WIDTH;
  localparam int SW = pbc_pkg::SUM_WIDTH;

  // box test; negated y is kept one bit wider so -(-32768) does not wrap
  logic signed [CW:0]  neg_y, y_low_ext, y_high_ext;
  pbc_pkg::coord_t     x_low, x_high, z_limit;
  logic                in_box;

  assign neg_y      = -$signed({point_y[CW-1], point_y});
  assign y_low_ext  = $signed({cfg.y_low_bound[CW-1], cfg.y_low_bound});
  assign y_high_ext = $signed({cfg.y_high_bound[CW-1], cfg.y_high_bound});
  assign x_low      = cfg.x_low_bound;
  assign x_high     = cfg.x_high_bound;
  assign z_limit    = cfg.depth_limit;

  assign in_box = point_valid && (neg_y > y_low_ext) && (neg_y < y_high_ext) &&
                  (point_x < x_high) && (point_x > x_low) && (point_z < z_limit);

  // accumulators
  pbc_pkg::sum_t   sum_of_x, sum_of_y;
  pbc_pkg::coord_t least_depth;
  pbc_pkg::count_t points_counted;

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      sum_of_x       <= '0;
      sum_of_y       <= '0;
      least_depth    <= pbc_pkg::COORD_MAX;
      points_counted <= '0;
    end else if (cmd.accept && in_box) begin
      if (points_counted < NW'(pbc_pkg::MAX_POINTS)) begin
        sum_of_x       <= sum_of_x + SW'(point_x);
        sum_of_y       <= sum_of_y + SW'(point_y);
        points_counted <= points_counted + NW'(1);
      end
      if (point_z < least_depth) begin
        least_depth <= point_z;
      end
    end
  end

  assign stat.centroid_found = (points_counted > cfg.min_point_count) &&
                               (least_depth <= z_limit);

  // divider: one quotient bit per cycle for both sums, sharing the divisor
  logic [SW-1:0]                    quo_x, quo_y;
  logic [NW-1:0]                    rem_x, rem_y, divisor;
  logic                             neg_x, neg_yq, has_r;
  pbc_pkg::coord_t                  res_z;
  logic [pbc_pkg::DIV_CNT_WIDTH-1:0] step_cnt;
  logic [NW:0]                      sh_x, sh_y, dif_x, dif_y;

  assign sh_x  = {rem_x, quo_x[SW-1]};
  assign sh_y  = {rem_y, quo_y[SW-1]};
  assign dif_x = sh_x - {1'b0, divisor};
  assign dif_y = sh_y - {1'b0, divisor};

  assign stat.div_last = (step_cnt == pbc_pkg::DIV_CNT_WIDTH'(SW - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo_x    <= sum_of_x[SW-1] ? SW'(-sum_of_x) : sum_of_x;
      quo_y    <= sum_of_y[SW-1] ? SW'(-sum_of_y) : sum_of_y;
      neg_x    <= sum_of_x[SW-1];
      neg_yq   <= sum_of_y[SW-1];
      rem_x    <= '0;
      rem_y    <= '0;
      divisor  <= points_counted;
      res_z    <= least_depth;
      has_r    <= stat.centroid_found;
      step_cnt <= '0;
    end else if (cmd.step) begin
      quo_x    <= {quo_x[SW-2:0], ~dif_x[NW]};
      quo_y    <= {quo_y[SW-2:0], ~dif_y[NW]};
      rem_x    <= dif_x[NW] ? sh_x[NW-1:0] : dif_x[NW-1:0];
      rem_y    <= dif_y[NW] ? sh_y[NW-1:0] : dif_y[NW-1:0];
      step_cnt <= step_cnt + pbc_pkg::DIV_CNT_WIDTH'(1);
    end
  end

  // output register
  pbc_pkg::coord_t q_x, q_y;

  assign q_x = neg_x  ? CW'(-quo_x[CW-1:0]) : quo_x[CW-1:0];
  assign q_y = neg_yq ? CW'(-quo_y[CW-1:0]) : quo_y[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      centroid_found <= has_r;
      centroid_x     <= has_r ? q_x : '0;
      centroid_y     <= has_r ? q_y : '0;
      nearest_z      <= has_r ? res_z : '0;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

/* sv/point_box_centroid_core.sv */
// Point box centroid core: points are taken one per cycle while a frame streams in;
// after the point marked frame_last, intake pauses while the block closes the frame
// (PREP) and, when a centroid is reported, runs a shared restoring divider (one
// quotient bit per cycle for x and y together, DIV), then loads the output register
// (LOAD) and takes points again. The result waits in the output register; the next
// frame is taken while it waits, and only the loading of the next result stalls
// until the previous one has been taken.
module point_box_centroid_core (
  input  logic                               clk,
  input  logic                               rst,
  pbc_point_if.sink                          point,
  pbc_result_if.source                       result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pbc_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [pbc_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [pbc_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);

  pbc_pkg::pbc_cfg_t  cfg;
  pbc_pkg::pbc_cmd_t  cmd;
  pbc_pkg::pbc_stat_t stat;

  pbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point.valid),
    .in_last  (point.frame_last),
    .in_ready (point.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .point_x        (point.point_x),
    .point_y        (point.point_y),
    .point_z        (point.point_z),
    .point_valid    (point.point_valid),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .centroid_found (result.centroid_found),
    .centroid_x     (result.centroid_x),
    .centroid_y     (result.centroid_y),
    .nearest_z      (result.nearest_z)
  );

  // intake stops once the last point of a frame is taken
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready && point.frame_last) |=> !point.ready)
    else $error("point taken right after frame end");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.centroid_found) |->
      (result.centroid_x == '0 && result.centroid_y == '0 && result.nearest_z == '0))
    else $error("nonzero fields without centroid");

  a_depth_ok: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.centroid_found) |-> (result.nearest_z <= cfg.depth_limit))
    else $error("reported depth beyond limit");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(result.valid && !result.ready))
    else $error("result overwritten before taken");

endmodule
